// ===== hw/rtl/p2y_pkg.sv =====
// Shared types, constants and arithmetic helpers for the palette to YUV 4:2:0 unit.
// Used by the channel interfaces, the colour conversion pipeline and the top level.
// Has no dependencies of its own.
package p2y_pkg;

  // Frame geometry limits and palette size.
  localparam int MaxWidth     = 4096;
  localparam int MaxHeight    = 4096;
  localparam int PaletteDepth = 256;

  // Field widths.
  localparam int ChanW    = 8;
  localparam int RgbW     = 3 * ChanW;
  localparam int IdxW     = $clog2(PaletteDepth);
  localparam int DimW     = 13;
  localparam int ColW     = $clog2(MaxWidth);
  localparam int RowW     = $clog2(MaxHeight);
  localparam int CfgIdxW  = 1;
  localparam int SumW     = 18;
  localparam int OffsetW  = 9;

  // BT.601 studio-range coefficients (magnitudes; signs are applied in the sums).
  localparam logic signed [SumW-1:0] YR  = 18'sd66;
  localparam logic signed [SumW-1:0] YG  = 18'sd129;
  localparam logic signed [SumW-1:0] YB  = 18'sd25;
  localparam logic signed [SumW-1:0] CbR = 18'sd38;
  localparam logic signed [SumW-1:0] CbG = 18'sd74;
  localparam logic signed [SumW-1:0] CbB = 18'sd112;
  localparam logic signed [SumW-1:0] CrR = 18'sd112;
  localparam logic signed [SumW-1:0] CrG = 18'sd94;
  localparam logic signed [SumW-1:0] CrB = 18'sd18;
  localparam logic [OffsetW-1:0]     LumaOffset   = 9'd16;
  localparam logic [OffsetW-1:0]     ChromaOffset = 9'd128;

  // Kinds of input transfer.
  typedef enum logic {
    REQ_PIXEL   = 1'b0,
    REQ_PALETTE = 1'b1
  } req_type_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  // Per-pixel flags that travel alongside the colour data.
  typedef struct packed {
    logic chroma_valid;
    logic frame_end;
  } p2y_tag_t;

  typedef logic signed [SumW-1:0] sum_t;

  // Rounds the weighted sum, shifts it down by eight with floor semantics,
  // adds the plane offset and clamps the result to 0..255.
  function automatic logic [ChanW-1:0] clamp_shift(sum_t sum, logic [OffsetW-1:0] offset);
    logic signed [SumW:0]    rnd;
    logic signed [SumW-9:0]  quo;
    logic signed [SumW-8:0]  val;
    logic [ChanW-1:0]        res;
    rnd = {sum[SumW-1], sum} + (SumW+1)'(128);
    quo = rnd[SumW-1:8];
    val = {quo[SumW-9], quo} + $signed({2'b00, offset});
    if (val < 0) begin
      res = '0;
    end else if (val > (SumW-7)'(255)) begin
      res = '1;
    end else begin
      res = val[ChanW-1:0];
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/p2y_if.sv =====
// Valid/ready channel interfaces for pixel input, YUV output and configuration writes.
// Depends on p2y_pkg for field widths.
interface p2y_in_if;
  logic                       valid;
  logic                       ready;
  logic                       req_type;
  logic [p2y_pkg::IdxW-1:0]   palette_index;
  logic [p2y_pkg::ChanW-1:0]  entry_red;
  logic [p2y_pkg::ChanW-1:0]  entry_green;
  logic [p2y_pkg::ChanW-1:0]  entry_blue;

  modport source (output valid, req_type, palette_index, entry_red, entry_green, entry_blue,
                  input ready);
  modport sink (input valid, req_type, palette_index, entry_red, entry_green, entry_blue,
                output ready);
endinterface

interface p2y_out_if;
  logic                       valid;
  logic                       ready;
  logic [p2y_pkg::ChanW-1:0]  luma;
  logic [p2y_pkg::ChanW-1:0]  chroma_blue;
  logic [p2y_pkg::ChanW-1:0]  chroma_red;
  logic                       chroma_valid;
  logic                       frame_end;

  modport source (output valid, luma, chroma_blue, chroma_red, chroma_valid, frame_end,
                  input ready);
  modport sink (input valid, luma, chroma_blue, chroma_red, chroma_valid, frame_end,
                output ready);
endinterface

interface p2y_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [p2y_pkg::CfgIdxW-1:0]  index;
  logic [p2y_pkg::DimW-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/p2y_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module p2y_ram #(
  parameter int Width = 24,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds while the read enable is low.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/p2y_csc.sv =====
// Colour space conversion pipeline: weighted RGB sums, then rounding, clamping and
// the output register. Depends on p2y_pkg and p2y_out_if.
module p2y_csc (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  output logic                          ready_o,
  input  logic [p2y_pkg::RgbW-1:0]      rgb_i,
  input  p2y_pkg::p2y_tag_t             tag_i,
  p2y_out_if.source                     out_o
);

  logic                  sum_valid_q;
  p2y_pkg::sum_t         y_sum_q, cb_sum_q, cr_sum_q;
  p2y_pkg::sum_t         y_sum_d, cb_sum_d, cr_sum_d;
  p2y_pkg::p2y_tag_t     sum_tag_q;
  p2y_pkg::sum_t         red, green, blue;

  logic                  out_valid_q;
  logic [p2y_pkg::ChanW-1:0] luma_q, cb_q, cr_q;
  logic [p2y_pkg::ChanW-1:0] luma_d, cb_d, cr_d;
  p2y_pkg::p2y_tag_t     out_tag_q;

  logic                  out_move;

  // Each stage advances when it is empty or its contents move on.
  assign out_move = !out_valid_q || out_o.ready;
  assign ready_o  = !sum_valid_q || out_move;

  // Weighted sums from the palette colour.
  always_comb begin
    red      = $signed({{(p2y_pkg::SumW-p2y_pkg::ChanW){1'b0}}, rgb_i[23:16]});
    green    = $signed({{(p2y_pkg::SumW-p2y_pkg::ChanW){1'b0}}, rgb_i[15:8]});
    blue     = $signed({{(p2y_pkg::SumW-p2y_pkg::ChanW){1'b0}}, rgb_i[7:0]});
    y_sum_d  = p2y_pkg::YR * red + p2y_pkg::YG * green + p2y_pkg::YB * blue;
    cb_sum_d = p2y_pkg::CbB * blue - p2y_pkg::CbR * red - p2y_pkg::CbG * green;
    cr_sum_d = p2y_pkg::CrR * red - p2y_pkg::CrG * green - p2y_pkg::CrB * blue;
  end

  // Rounding and clamping; chroma reads as zero off the subsampling grid.
  always_comb begin
    luma_d = p2y_pkg::clamp_shift(y_sum_q, p2y_pkg::LumaOffset);
    cb_d   = '0;
    cr_d   = '0;
    if (sum_tag_q.chroma_valid) begin
      cb_d = p2y_pkg::clamp_shift(cb_sum_q, p2y_pkg::ChromaOffset);
      cr_d = p2y_pkg::clamp_shift(cr_sum_q, p2y_pkg::ChromaOffset);
    end
  end

  // Stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ready_o) begin
        sum_valid_q <= valid_i;
      end
      if (out_move) begin
        out_valid_q <= sum_valid_q;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (ready_o) begin
      y_sum_q   <= y_sum_d;
      cb_sum_q  <= cb_sum_d;
      cr_sum_q  <= cr_sum_d;
      sum_tag_q <= tag_i;
    end
    if (out_move) begin
      luma_q    <= luma_d;
      cb_q      <= cb_d;
      cr_q      <= cr_d;
      out_tag_q <= sum_tag_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.luma         = luma_q;
  assign out_o.chroma_blue  = cb_q;
  assign out_o.chroma_red   = cr_q;
  assign out_o.chroma_valid = out_tag_q.chroma_valid;
  assign out_o.frame_end    = out_tag_q.frame_end;

endmodule

// ===== hw/rtl/palette_to_yuv420_planar_unit.sv =====
// Palette-indexed pixels to BT.601 YCbCr 4:2:0: palette RAM, raster counters and the
// conversion pipeline. Depends on p2y_pkg, the channel interfaces, p2y_ram and p2y_csc.
// A pixel passes the palette read register, the sum stage and the output register; any
// stage can stall on output back-pressure. Throughput: one transfer per cycle, pixel or
// palette write, while the output is not stalled, set by the single input channel.
// Reset clears the counters and the pipeline and sets the geometry to 720 x 576;
// palette entries are undefined until written, and no clearing pass runs.
module palette_to_yuv420_planar_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  p2y_cfg_if.sink   cfg_i,
  p2y_in_if.sink    in_i,
  p2y_out_if.source out_o
);

  logic [p2y_pkg::DimW-1:0]  width_q, height_q;
  logic [p2y_pkg::ColW-1:0]  col_q, col_d, col_last;
  logic [p2y_pkg::RowW-1:0]  row_q, row_d, row_last;
  logic                      last_col, last_row;
  logic                      in_xfer, pixel_xfer, palette_xfer;
  logic                      pix_valid_q, csc_ready;
  p2y_pkg::p2y_tag_t         tag_d, pix_tag_q;
  logic [p2y_pkg::RgbW-1:0]  rgb;

  // Configuration writes are always taken.
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= p2y_pkg::DimW'(720);
      height_q <= p2y_pkg::DimW'(576);
    end else if (cfg_i.valid) begin
      if (cfg_i.index == p2y_pkg::CFG_FRAME_WIDTH) begin
        width_q <= cfg_i.data;
      end
      if (cfg_i.index == p2y_pkg::CFG_FRAME_HEIGHT) begin
        height_q <= cfg_i.data;
      end
    end
  end

  // Last column and row indexes from the saturated geometry.
  always_comb begin
    if (width_q == '0) begin
      col_last = '0;
    end else if ({1'b0, width_q} > (p2y_pkg::DimW+1)'(p2y_pkg::MaxWidth)) begin
      col_last = p2y_pkg::ColW'(p2y_pkg::MaxWidth - 1);
    end else begin
      col_last = p2y_pkg::ColW'(width_q - 1'b1);
    end
    if (height_q == '0) begin
      row_last = '0;
    end else if ({1'b0, height_q} > (p2y_pkg::DimW+1)'(p2y_pkg::MaxHeight)) begin
      row_last = p2y_pkg::RowW'(p2y_pkg::MaxHeight - 1);
    end else begin
      row_last = p2y_pkg::RowW'(height_q - 1'b1);
    end
  end

  // Input handshake: the first stage takes a transfer when it is empty or moving on.
  assign in_i.ready   = !pix_valid_q || csc_ready;
  assign in_xfer      = in_i.valid && in_i.ready;
  assign pixel_xfer   = in_xfer && (in_i.req_type == p2y_pkg::REQ_PIXEL);
  assign palette_xfer = in_xfer && (in_i.req_type == p2y_pkg::REQ_PALETTE);

  // Raster position and per-pixel flags.
  always_comb begin
    last_col           = col_q >= col_last;
    last_row           = row_q >= row_last;
    tag_d.chroma_valid = !row_q[0] && !col_q[0];
    tag_d.frame_end    = last_col && last_row;
    col_d              = col_q + 1'b1;
    row_d              = row_q;
    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q       <= '0;
      row_q       <= '0;
      pix_valid_q <= 1'b0;
    end else begin
      if (pixel_xfer) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (in_i.ready) begin
        pix_valid_q <= pixel_xfer;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready) begin
      pix_tag_q <= tag_d;
    end
  end

  // Palette store; the read data lines up with the first pipeline stage.
  p2y_ram #(
    .Width (p2y_pkg::RgbW),
    .Depth (p2y_pkg::PaletteDepth)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (palette_xfer),
    .waddr_i (in_i.palette_index),
    .wdata_i ({in_i.entry_red, in_i.entry_green, in_i.entry_blue}),
    .re_i    (in_i.ready),
    .raddr_i (in_i.palette_index),
    .rdata_o (rgb)
  );

  // Conversion pipeline and output register.
  p2y_csc u_csc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (pix_valid_q),
    .ready_o (csc_ready),
    .rgb_i   (rgb),
    .tag_i   (pix_tag_q),
    .out_o   (out_o)
  );

  // A palette write never enters the conversion pipeline.
  a_palette_no_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    palette_xfer |=> !pix_valid_q)
    else $error("palette write entered the pixel pipeline");

  // Within a row the column advances by one per pixel.
  a_col_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pixel_xfer && !last_col) |=> (col_q == $past(col_q) + 1'b1) && $stable(row_q))
    else $error("column counter did not advance");

  // After the last pixel of a frame both counters return to zero.
  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pixel_xfer && last_col && last_row) |=> (col_q == '0) && (row_q == '0))
    else $error("counters did not wrap at frame end");

  // Counters only move on a pixel transfer.
  a_count_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pixel_xfer |=> $stable(col_q) && $stable(row_q))
    else $error("counters moved without a pixel transfer");

endmodule
